### rtl/core/fcl_pkg.sv
// fcl_pkg: types, character codes and command codes for the framed command link
// used by framed_command_link_fsm and its port checker; depends on nothing

package fcl_pkg;

  localparam logic [7:0] CH_START = 8'h21;  // '!'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'

  // word kinds on the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // body lengths, the '!' counted, of "!RST" and "!OK"
  localparam logic [4:0] RST_BODY_LEN = 5'd4;
  localparam logic [4:0] OK_BODY_LEN  = 5'd3;

  localparam logic [7:0] RST_TEXT [4] = '{8'h21, 8'h52, 8'h53, 8'h54};
  localparam logic [7:0] OK_TEXT  [4] = '{8'h21, 8'h4F, 8'h4B, 8'h00};

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_NONE  = 2'd0;
  localparam cmd_code_t CMD_RST   = 2'd1;
  localparam cmd_code_t CMD_OK    = 2'd2;
  localparam cmd_code_t CMD_OTHER = 2'd3;

  // register word index taken from paddr[2]
  localparam logic REG_RESEND_PERIOD = 1'b0;
  localparam logic [15:0] RESEND_PERIOD_RESET = 16'd300;

  typedef struct packed {
    logic        send_report;
    logic [11:0] report_value;
    cmd_code_t   command_code;
    logic        link_sending;
  } result_t;

endpackage

### rtl/core/framed_command_link_fsm.sv
// framed_command_link_fsm: byte framer, command matcher and report timer
// depends on fcl_pkg for character codes, command codes and the result type
//
// usage:
//  - input channel (in_valid/in_ready) carries one word per cycle while in_ready
//    is high: a received byte (in_operation 0) or a timer tick (in_operation 1),
//    together with the current adc sample
//  - every input word yields exactly one result word on out_valid/out_ready:
//    report strobe, latched adc value, completed command code, link state
//  - the result is registered: it is in the output register the cycle after
//    the word is taken; throughput is one word per cycle while the output is
//    not stalled, set by the single framer/timer update done in the accept cycle
//  - in_ready stays high while the output register is empty or being taken,
//    so a stalled receiver holds its result and blocks only further input
//  - the resend period is written through the apb port at address 0, by the user
//    only while the block is idle (not enforced by the block); a period of 0 acts as 1
//  - synchronous reset (rst_n low) clears the framer, stops reporting, clears
//    the latched value and empties the output register; the period returns
//    to 300

module framed_command_link_fsm #(
  parameter int FRAME_MAX_LEN = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [11:0] in_adc_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_report,
  output logic [11:0] out_report_value,
  output logic [1:0]  out_command_code,
  output logic        out_link_sending,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [5:0] MAX_LEN = 6'(FRAME_MAX_LEN);

  logic [15:0] resend_period_r;
  logic        in_frame_r, in_frame_nxt;
  logic [4:0]  frame_len_r, frame_len_nxt;
  logic        reset_match_r, reset_match_nxt;
  logic        ok_match_r, ok_match_nxt;
  logic        reporting_r, reporting_nxt;
  logic [15:0] resend_timer_r, resend_timer_nxt;
  logic [11:0] latched_adc_r, latched_adc_nxt;
  logic        out_valid_r;
  fcl_pkg::result_t result_r, result_nxt;

  logic        accept;
  logic        cfg_write;
  fcl_pkg::cmd_code_t code;
  logic [4:0]  pos;
  logic [15:0] timer_dec;
  logic        report;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == fcl_pkg::REG_RESEND_PERIOD);
  assign prdata    = (paddr[2] == fcl_pkg::REG_RESEND_PERIOD) ? {16'd0, resend_period_r}
                                                              : 32'd0;

  // framer
  always_comb begin
    in_frame_nxt    = in_frame_r;
    frame_len_nxt   = frame_len_r;
    reset_match_nxt = reset_match_r;
    ok_match_nxt    = ok_match_r;
    code            = fcl_pkg::CMD_NONE;
    pos             = frame_len_r;
    if (in_operation == fcl_pkg::OP_BYTE) begin
      if (!in_frame_r) begin
        if (in_rx_byte == fcl_pkg::CH_START) begin
          in_frame_nxt    = 1'b1;
          frame_len_nxt   = 5'd1;
          reset_match_nxt = 1'b1;
          ok_match_nxt    = 1'b1;
        end
      end else if ({1'b0, pos} + 6'd1 >= MAX_LEN) begin
        // overlong frame is dropped even on the end character
        in_frame_nxt    = 1'b0;
        frame_len_nxt   = 5'd0;
        reset_match_nxt = 1'b0;
        ok_match_nxt    = 1'b0;
      end else if (in_rx_byte == fcl_pkg::CH_END) begin
        if (reset_match_r && pos == fcl_pkg::RST_BODY_LEN) begin
          code = fcl_pkg::CMD_RST;
        end else if (ok_match_r && pos == fcl_pkg::OK_BODY_LEN) begin
          code = fcl_pkg::CMD_OK;
        end else begin
          code = fcl_pkg::CMD_OTHER;
        end
        in_frame_nxt    = 1'b0;
        frame_len_nxt   = 5'd0;
        reset_match_nxt = 1'b0;
        ok_match_nxt    = 1'b0;
      end else begin
        frame_len_nxt   = pos + 5'd1;
        reset_match_nxt = reset_match_r && (pos < fcl_pkg::RST_BODY_LEN)
                          && (in_rx_byte == fcl_pkg::RST_TEXT[pos[1:0]]);
        ok_match_nxt    = ok_match_r && (pos < fcl_pkg::OK_BODY_LEN)
                          && (in_rx_byte == fcl_pkg::OK_TEXT[pos[1:0]]);
      end
    end
  end

  // link state and report timer
  always_comb begin
    latched_adc_nxt  = latched_adc_r;
    reporting_nxt    = reporting_r;
    resend_timer_nxt = resend_timer_r;
    report           = 1'b0;
    if (!reporting_r) begin
      latched_adc_nxt = in_adc_sample;
      if (code == fcl_pkg::CMD_RST) begin
        reporting_nxt    = 1'b1;
        resend_timer_nxt = 16'd1;
      end
    end else if (code == fcl_pkg::CMD_OK) begin
      reporting_nxt    = 1'b0;
      resend_timer_nxt = 16'd0;
    end
    timer_dec = resend_timer_nxt - 16'd1;
    if (in_operation == fcl_pkg::OP_TICK && reporting_nxt
        && resend_timer_nxt != 16'd0) begin
      resend_timer_nxt = timer_dec;
      if (timer_dec == 16'd0) begin
        report           = 1'b1;
        resend_timer_nxt = (resend_period_r != 16'd0) ? resend_period_r : 16'd1;
      end
    end
    result_nxt.send_report  = report;
    result_nxt.report_value = latched_adc_nxt;
    result_nxt.command_code = code;
    result_nxt.link_sending = reporting_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_period_r <= fcl_pkg::RESEND_PERIOD_RESET;
      in_frame_r      <= 1'b0;
      frame_len_r     <= 5'd0;
      reset_match_r   <= 1'b0;
      ok_match_r      <= 1'b0;
      reporting_r     <= 1'b0;
      resend_timer_r  <= 16'd0;
      latched_adc_r   <= 12'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_write) begin
        resend_period_r <= pwdata[15:0];
      end
      if (accept) begin
        in_frame_r     <= in_frame_nxt;
        frame_len_r    <= frame_len_nxt;
        reset_match_r  <= reset_match_nxt;
        ok_match_r     <= ok_match_nxt;
        reporting_r    <= reporting_nxt;
        resend_timer_r <= resend_timer_nxt;
        latched_adc_r  <= latched_adc_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_report  = result_r.send_report;
  assign out_report_value = result_r.report_value;
  assign out_command_code = result_r.command_code;
  assign out_link_sending = result_r.link_sending;

endmodule

### rtl/core/fcl_checker.sv
// fcl_checker: port-level assertions for framed_command_link_fsm
// depends on fcl_pkg for command codes; bound to framed_command_link_fsm below

module fcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_send_report,
  input logic [11:0] out_report_value,
  input logic [1:0]  out_command_code,
  input logic        out_link_sending
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_report)
      && $stable(out_report_value) && $stable(out_command_code)
      && $stable(out_link_sending))
    else $error("result word changed while stalled");

  // reports only go out while the link is sending
  a_report_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_report |-> out_link_sending)
    else $error("report raised while link idle");

  // after an ok frame the link is always idle
  a_ok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_code == fcl_pkg::CMD_OK |-> !out_link_sending)
    else $error("link still sending after ok frame");

  // empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind framed_command_link_fsm fcl_checker u_fcl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_send_report  (out_send_report),
  .out_report_value (out_report_value),
  .out_command_code (out_command_code),
  .out_link_sending (out_link_sending)
);
